### hw/rtl/rmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_pkg: shared types and constants for the record message deframer
// Event codes, parser phases and the command word that passes from the
// byte parser to the result serializer.
// ----------------------------------------------------------------------------
package rmd_pkg;

    // Header length in bytes: id, type, sender, receiver, record count
    localparam int HDR_LEN = 5;

    // Default depth of the parser-to-serializer command queue
    localparam int QUEUE_DEPTH = 4;

    // Result event codes
    typedef enum logic [2:0] {
        EV_HEADER = 3'd0,
        EV_DATA   = 3'd1,
        EV_EMPTY  = 3'd2,
        EV_DONE   = 3'd3,
        EV_SHORT  = 3'd4,
        EV_OVER   = 3'd5
    } ev_t;

    // Parser phase: header positions, then record length / data, then done
    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_HDR2 = 3'd2,
        PH_HDR3 = 3'd3,
        PH_HDR4 = 3'd4,
        PH_LEN  = 3'd5,
        PH_DATA = 3'd6,
        PH_DONE = 3'd7
    } phase_t;

    typedef logic [HDR_LEN-1:0][7:0] hdr_t;

    // One accepted byte's worth of results: one or two beats
    typedef struct packed {
        ev_t        ev0;
        ev_t        ev1;
        logic       two;
        logic [7:0] idx0;
        logic [7:0] idx1;
        logic [7:0] data;
        logic       rend;
        hdr_t       hdr;
    } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/record_message_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_message_deframer: length-prefixed record message parser
// Reads a five-byte header and then length-prefixed records, one byte per
// beat, and reports header, data bytes, empty records, completion and
// truncation as result beats.
// ----------------------------------------------------------------------------
// The block takes one byte per clock while its command queue has room. The
// parser handles each byte in the cycle it is accepted and queues zero, one
// or two result beats; the serializer sends one result beat per clock while
// the receiver takes them, through an output register. A byte that produces
// two results (header plus done or overflow, empty record plus done or
// overflow, data byte plus overflow, last data byte plus done) occupies the
// output for both of its beats, so over long runs bytes follow back to back
// only while result beats do not outnumber bytes; beyond that the input is
// held back for each extra beat, with the QUEUE_DEPTH-entry queue absorbing
// short bursts. An accepted byte's first result beat passes through the
// command queue and then the output register. After a byte flagged as the
// buffer end the parser starts a fresh message on the next byte.
// ----------------------------------------------------------------------------
module record_message_deframer #(
    parameter int QUEUE_DEPTH = rmd_pkg::QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_buffer_end,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_event_res,
    output logic [7:0]      m_packet_id,
    output logic [7:0]      m_msg_type,
    output logic [7:0]      m_sender,
    output logic [7:0]      m_receiver,
    output logic [7:0]      m_record_count,
    output logic [7:0]      m_record_index,
    output logic [7:0]      m_data_byte,
    output logic            m_record_end,
    output logic            m_last
);

    rmd_pkg::cmd_t q_cmd, q_head;
    logic          q_push, q_full, q_pop, q_empty;

    // Parser
    rmd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_in_byte),
        .buffer_end (s_buffer_end),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (q_cmd)
    );

    // Command queue
    rmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    // Result serializer
    rmd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (q_head),
        .empty          (q_empty),
        .pop            (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .m_packet_id    (m_packet_id),
        .m_msg_type     (m_msg_type),
        .m_sender       (m_sender),
        .m_receiver     (m_receiver),
        .m_record_count (m_record_count),
        .m_record_index (m_record_index),
        .m_data_byte    (m_data_byte),
        .m_record_end   (m_record_end),
        .m_last         (m_last)
    );

endmodule
`default_nettype wire

### hw/rtl/rmd_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_front: byte parser
// Tracks header position, record count and bytes left in the current
// record, and turns each accepted byte into a command of zero, one or two
// result beats.
// ----------------------------------------------------------------------------
module rmd_front (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       buffer_end,
    input  wire logic       q_full,
    output logic            q_push,
    output rmd_pkg::cmd_t   q_cmd
);

    rmd_pkg::phase_t phase_reg, phase_next;
    rmd_pkg::hdr_t   hdr_reg, hdr_next;
    logic [7:0]      rd_reg, rd_next;
    logic [7:0]      bl_reg, bl_next;

    logic            accept;
    logic            have0;
    logic            rend;
    logic [7:0]      rd_inc;

    assign in_ready = ~q_full;
    assign accept   = in_valid & ~q_full;
    assign rd_inc   = rd_reg + 8'd1;
    assign rend     = (bl_reg <= 8'd1);

    // Parse one byte
    always_comb begin
        phase_next = phase_reg;
        hdr_next   = hdr_reg;
        rd_next    = rd_reg;
        bl_next    = bl_reg;
        have0      = 1'b0;
        q_cmd      = '0;
        q_cmd.ev0  = rmd_pkg::EV_HEADER;
        q_cmd.ev1  = rmd_pkg::EV_HEADER;

        unique case (phase_reg)
            rmd_pkg::PH_HDR0, rmd_pkg::PH_HDR1,
            rmd_pkg::PH_HDR2, rmd_pkg::PH_HDR3: begin
                hdr_next[phase_reg[2:0]] = in_byte;
                phase_next = rmd_pkg::phase_t'(phase_reg + 3'd1);
                if (buffer_end) begin
                    have0      = 1'b1;
                    q_cmd.ev0  = rmd_pkg::EV_SHORT;
                    q_cmd.idx0 = rd_reg;
                end
            end
            rmd_pkg::PH_HDR4: begin
                hdr_next[rmd_pkg::HDR_LEN-1] = in_byte;
                rd_next    = 8'd0;
                have0      = 1'b1;
                q_cmd.ev0  = rmd_pkg::EV_HEADER;
                q_cmd.idx0 = 8'd0;
                if (in_byte == 8'd0) begin
                    phase_next = rmd_pkg::PH_DONE;
                    q_cmd.two  = 1'b1;
                    q_cmd.ev1  = rmd_pkg::EV_DONE;
                    q_cmd.idx1 = 8'd0;
                end else begin
                    phase_next = rmd_pkg::PH_LEN;
                end
            end
            rmd_pkg::PH_LEN: begin
                if (in_byte == 8'd0) begin
                    // empty record counts as finished at once
                    have0      = 1'b1;
                    q_cmd.ev0  = rmd_pkg::EV_EMPTY;
                    q_cmd.idx0 = rd_reg;
                    rd_next    = rd_inc;
                    if (rd_inc == hdr_reg[rmd_pkg::HDR_LEN-1]) begin
                        phase_next = rmd_pkg::PH_DONE;
                        q_cmd.two  = 1'b1;
                        q_cmd.ev1  = rmd_pkg::EV_DONE;
                        q_cmd.idx1 = rd_inc;
                    end
                end else begin
                    bl_next    = in_byte;
                    phase_next = rmd_pkg::PH_DATA;
                end
            end
            rmd_pkg::PH_DATA: begin
                have0      = 1'b1;
                q_cmd.ev0  = rmd_pkg::EV_DATA;
                q_cmd.idx0 = rd_reg;
                q_cmd.data = in_byte;
                q_cmd.rend = rend;
                bl_next    = rend ? 8'd0 : bl_reg - 8'd1;
                if (rend) begin
                    rd_next = rd_inc;
                    if (rd_inc == hdr_reg[rmd_pkg::HDR_LEN-1]) begin
                        phase_next = rmd_pkg::PH_DONE;
                        q_cmd.two  = 1'b1;
                        q_cmd.ev1  = rmd_pkg::EV_DONE;
                        q_cmd.idx1 = rd_inc;
                    end else begin
                        phase_next = rmd_pkg::PH_LEN;
                    end
                end
            end
            rmd_pkg::PH_DONE: begin
                // trailing bytes are dropped
            end
            default: begin
            end
        endcase

        q_cmd.hdr = hdr_next;

        // Buffer end: flag missing records, then start over
        if (buffer_end) begin
            if (phase_next == rmd_pkg::PH_LEN || phase_next == rmd_pkg::PH_DATA) begin
                if (have0) begin
                    q_cmd.two  = 1'b1;
                    q_cmd.ev1  = rmd_pkg::EV_OVER;
                    q_cmd.idx1 = rd_next;
                end else begin
                    have0      = 1'b1;
                    q_cmd.ev0  = rmd_pkg::EV_OVER;
                    q_cmd.idx0 = rd_next;
                end
            end
            phase_next = rmd_pkg::PH_HDR0;
            hdr_next   = '0;
            rd_next    = 8'd0;
            bl_next    = 8'd0;
        end
    end

    assign q_push = accept & have0;

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rmd_pkg::PH_HDR0;
            hdr_reg   <= '0;
            rd_reg    <= 8'd0;
            bl_reg    <= 8'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            rd_reg    <= rd_next;
            bl_reg    <= bl_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/rmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_queue: command queue
// Small register FIFO between parser and serializer; head is visible
// without a read cycle.
// ----------------------------------------------------------------------------
module rmd_queue #(
    parameter int DEPTH = rmd_pkg::QUEUE_DEPTH
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire rmd_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output rmd_pkg::cmd_t      head,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rmd_pkg::cmd_t     mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign head    = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### hw/rtl/rmd_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rmd_back: result serializer
// Splits each queued command into one or two result beats and holds them
// in the output register until taken.
// ----------------------------------------------------------------------------
module rmd_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rmd_pkg::cmd_t head,
    input  wire logic          empty,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output logic [2:0]         m_event_res,
    output logic [7:0]         m_packet_id,
    output logic [7:0]         m_msg_type,
    output logic [7:0]         m_sender,
    output logic [7:0]         m_receiver,
    output logic [7:0]         m_record_count,
    output logic [7:0]         m_record_index,
    output logic [7:0]         m_data_byte,
    output logic               m_record_end,
    output logic               m_last
);

    logic         sec_reg;
    logic         valid_reg;
    logic         load;
    logic         final_beat;
    rmd_pkg::ev_t ev;

    logic [2:0]   ev_reg;
    logic [7:0]   id_reg, ty_reg, snd_reg, rcv_reg, cnt_reg;
    logic [7:0]   idx_reg, data_reg;
    logic         rend_reg, last_reg;

    assign load       = ~empty & (~valid_reg | m_ready);
    assign final_beat = sec_reg | ~head.two;
    assign pop        = load & final_beat;
    assign ev         = sec_reg ? head.ev1 : head.ev0;

    // Beat select and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sec_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                sec_reg   <= ~final_beat;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (load) begin
            ev_reg   <= ev;
            id_reg   <= head.hdr[0];
            ty_reg   <= head.hdr[1];
            snd_reg  <= head.hdr[2];
            rcv_reg  <= head.hdr[3];
            cnt_reg  <= head.hdr[4];
            idx_reg  <= sec_reg ? head.idx1 : head.idx0;
            data_reg <= sec_reg ? 8'd0 : head.data;
            rend_reg <= sec_reg ? 1'b0 : head.rend;
            last_reg <= final_beat;
        end
    end

    assign m_valid        = valid_reg;
    assign m_event_res    = ev_reg;
    assign m_packet_id    = id_reg;
    assign m_msg_type     = ty_reg;
    assign m_sender       = snd_reg;
    assign m_receiver     = rcv_reg;
    assign m_record_count = cnt_reg;
    assign m_record_index = idx_reg;
    assign m_data_byte    = data_reg;
    assign m_record_end   = rend_reg;
    assign m_last         = last_reg;

endmodule
`default_nettype wire
